/* rtl/core/dbpp_pkg.sv */
// shared types, constants and helpers for the dot-bracket pair parser
package dbpp_pkg;

  // record length limit, the widths that follow from it, and the character and config widths
  localparam int MaxLen   = 1024;
  localparam int IdxW     = 10;
  localparam int PosW     = 11;
  localparam int CharW    = 8;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  // register map
  localparam logic [CfgAddrW-1:0] REG_UNION_MODE = 3'd0;

  // characters
  localparam logic [CharW-1:0] CH_A      = 8'h41;
  localparam logic [CharW-1:0] CH_U      = 8'h55;
  localparam logic [CharW-1:0] CH_G      = 8'h47;
  localparam logic [CharW-1:0] CH_C      = 8'h43;
  localparam logic [CharW-1:0] CH_T      = 8'h54;
  localparam logic [CharW-1:0] CH_DOT    = 8'h2E;
  localparam logic [CharW-1:0] CH_LPAREN = 8'h28;
  localparam logic [CharW-1:0] CH_RPAREN = 8'h29;
  localparam logic [CharW-1:0] CH_LSQ    = 8'h5B;
  localparam logic [CharW-1:0] CH_RSQ    = 8'h5D;

  // record status codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_T_BASE    = 3'd1,
    ERR_BASE      = 3'd2,
    ERR_SYMBOL    = 3'd3,
    ERR_UNMATCHED = 3'd4,
    ERR_MISSING   = 3'd5,
    ERR_OVERLAP   = 3'd6,
    ERR_TOO_LONG  = 3'd7
  } err_code_t;

  // first error of one category
  typedef struct packed {
    err_code_t       code;
    logic [PosW-1:0] pos;
  } err_t;

  // stack memory request
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [IdxW-1:0] wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } ram_req_t;

  // per-word info travelling to the output stage
  typedef struct packed {
    logic            pair_valid;
    logic            sel_round;
    logic [IdxW-1:0] right_pos;
    err_code_t       status;
    logic [PosW-1:0] error_position;
    logic            record_done;
  } stage_t;

  // keep the first error only
  function automatic err_t note(err_t cur, err_code_t code, logic [PosW-1:0] pos);
    err_t res;
    res = cur;
    if (cur.code == ERR_NONE) begin
      res.code = code;
      res.pos  = pos;
    end
    return res;
  endfunction

endpackage

/* rtl/core/dbpp_if.sv */
// word channels for incoming positions and outgoing results
interface dbpp_item_if;
  logic                       valid;
  logic                       ready;
  logic [dbpp_pkg::CharW-1:0] base_char;
  logic [dbpp_pkg::CharW-1:0] struct_char;
  logic [dbpp_pkg::CharW-1:0] alt_struct_char;
  logic                       last;

  modport source (output valid, base_char, struct_char, alt_struct_char, last, input ready);
  modport sink (input valid, base_char, struct_char, alt_struct_char, last, output ready);
endinterface

interface dbpp_result_if;
  logic                      valid;
  logic                      ready;
  logic                      pair_valid;
  logic [dbpp_pkg::IdxW-1:0] left_pos;
  logic [dbpp_pkg::IdxW-1:0] right_pos;
  logic [2:0]                status;
  logic [dbpp_pkg::PosW-1:0] error_position;
  logic                      record_done;

  modport source (output valid, pair_valid, left_pos, right_pos, status, error_position,
                  record_done, input ready);
  modport sink (input valid, pair_valid, left_pos, right_pos, status, error_position,
                record_done, output ready);
endinterface

/* rtl/core/dbpp_ram.sv */
// generic single-write, single-read ram with registered read
module dbpp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/dbpp_cfg.sv */
// apb register block holding the union mode bit
module dbpp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbpp_pkg::CfgAddrW-1:0] paddr,
  input  logic [dbpp_pkg::CfgDataW-1:0] pwdata,
  output logic [dbpp_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output logic                          union_mode
);
  import dbpp_pkg::*;

  logic wr_union;

  // write decode
  assign wr_union = psel && penable && pwrite && (paddr == REG_UNION_MODE);
  assign pready   = 1'b1;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      union_mode <= 1'b0;
    end else if (wr_union) begin
      union_mode <= pwdata[0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == REG_UNION_MODE) begin
      prdata = {{(CfgDataW-1){1'b0}}, union_mode};
    end
  end

endmodule

/* rtl/core/dbpp_front.sv */
// symbol decode, stack pointers, error capture and stack memory requests
module dbpp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       union_mode,
  input  logic [dbpp_pkg::CharW-1:0] base_char,
  input  logic [dbpp_pkg::CharW-1:0] struct_char,
  input  logic [dbpp_pkg::CharW-1:0] alt_struct_char,
  input  logic                       last,
  output dbpp_pkg::ram_req_t         round_req,
  output dbpp_pkg::ram_req_t         square_req,
  output dbpp_pkg::stage_t           stage
);
  import dbpp_pkg::*;

  logic [PosW-1:0] round_top, round_top_next;
  logic [PosW-1:0] square_top, square_top_next;
  logic [PosW-1:0] position;
  logic            overflow, overflow_next;
  err_t            sequence_error, sequence_error_next;
  err_t            round_part_error, round_part_error_next;
  err_t            square_part_error, square_part_error_next;
  err_t            overlap_error, overlap_error_next;

  logic            r_push, r_popq, r_pop;
  logic            s_push, s_popq, s_pop;
  logic [PosW-1:0] op;
  logic [IdxW-1:0] pos_idx;
  err_t            r_fin, s_fin, fin;

  assign op      = position + PosW'(1);
  assign pos_idx = position[IdxW-1:0];

  // decode and next state for one position
  always_comb begin
    overflow_next          = overflow || (position >= PosW'(MaxLen));
    sequence_error_next    = sequence_error;
    round_part_error_next  = round_part_error;
    square_part_error_next = square_part_error;
    overlap_error_next     = overlap_error;
    r_push = 1'b0;
    r_popq = 1'b0;
    s_push = 1'b0;
    s_popq = 1'b0;
    if (!overflow_next) begin
      if (!(base_char == CH_A || base_char == CH_U || base_char == CH_G ||
            base_char == CH_C)) begin
        sequence_error_next = note(sequence_error, (base_char == CH_T) ? ERR_T_BASE : ERR_BASE,
                                   op);
      end
      if (!union_mode) begin
        case (struct_char)
          CH_LPAREN: r_push = 1'b1;
          CH_LSQ:    s_push = 1'b1;
          CH_RPAREN: r_popq = 1'b1;
          CH_RSQ:    s_popq = 1'b1;
          CH_DOT:    ;
          default:   round_part_error_next = note(round_part_error, ERR_SYMBOL, op);
        endcase
      end else begin
        case (struct_char)
          CH_LPAREN: r_push = 1'b1;
          CH_RPAREN: r_popq = 1'b1;
          CH_DOT:    ;
          default:   round_part_error_next = note(round_part_error, ERR_SYMBOL, op);
        endcase
        case (alt_struct_char)
          CH_LSQ:  s_push = 1'b1;
          CH_RSQ:  s_popq = 1'b1;
          CH_DOT:  ;
          default: square_part_error_next = note(square_part_error, ERR_SYMBOL, op);
        endcase
        if (struct_char != CH_DOT && alt_struct_char != CH_DOT) begin
          overlap_error_next = note(overlap_error, ERR_OVERLAP, op);
        end
      end
    end
    r_pop = r_popq && (round_top != '0);
    s_pop = s_popq && (square_top != '0);
    // unmatched closers
    if (r_popq && !r_pop) begin
      round_part_error_next = note(round_part_error_next, ERR_UNMATCHED, op);
    end
    if (s_popq && !s_pop) begin
      if (union_mode) begin
        square_part_error_next = note(square_part_error_next, ERR_UNMATCHED, op);
      end else begin
        round_part_error_next = note(round_part_error_next, ERR_UNMATCHED, op);
      end
    end
    r_push = r_push && (round_top < PosW'(MaxLen));
    s_push = s_push && (square_top < PosW'(MaxLen));
    round_top_next  = round_top + PosW'(r_push) - PosW'(r_pop);
    square_top_next = square_top + PosW'(s_push) - PosW'(s_pop);
  end

  // final status by priority on the last position
  always_comb begin
    r_fin = round_part_error_next;
    s_fin = square_part_error_next;
    if (!union_mode) begin
      if (r_fin.code == ERR_NONE && (round_top_next != '0 || square_top_next != '0)) begin
        r_fin = '{code: ERR_MISSING, pos: '0};
      end
    end else begin
      if (r_fin.code == ERR_NONE && round_top_next != '0) begin
        r_fin = '{code: ERR_MISSING, pos: '0};
      end
      if (s_fin.code == ERR_NONE && square_top_next != '0) begin
        s_fin = '{code: ERR_MISSING, pos: '0};
      end
    end
    if (overflow_next) begin
      fin = '{code: ERR_TOO_LONG, pos: '0};
    end else if (sequence_error_next.code != ERR_NONE) begin
      fin = sequence_error_next;
    end else if (r_fin.code != ERR_NONE) begin
      fin = r_fin;
    end else if (s_fin.code != ERR_NONE) begin
      fin = s_fin;
    end else begin
      fin = overlap_error_next;
    end
  end

  // stack memory requests: push at top, pop reads top minus one
  always_comb begin
    round_req.we     = accept && r_push;
    round_req.waddr  = round_top[IdxW-1:0];
    round_req.wdata  = pos_idx;
    round_req.re     = accept && r_pop;
    round_req.raddr  = round_top[IdxW-1:0] - IdxW'(1);
    square_req.we    = accept && s_push;
    square_req.waddr = square_top[IdxW-1:0];
    square_req.wdata = pos_idx;
    square_req.re    = accept && s_pop;
    square_req.raddr = square_top[IdxW-1:0] - IdxW'(1);
  end

  // word info for the output stage
  always_comb begin
    stage.pair_valid     = r_pop || s_pop;
    stage.sel_round      = r_pop;
    stage.right_pos      = (r_pop || s_pop) ? pos_idx : '0;
    stage.status         = last ? fin.code : ERR_NONE;
    stage.error_position = last ? fin.pos : '0;
    stage.record_done    = last;
  end

  // record state
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      round_top         <= '0;
      square_top        <= '0;
      position          <= '0;
      overflow          <= 1'b0;
      sequence_error    <= '{code: ERR_NONE, pos: '0};
      round_part_error  <= '{code: ERR_NONE, pos: '0};
      square_part_error <= '{code: ERR_NONE, pos: '0};
      overlap_error     <= '{code: ERR_NONE, pos: '0};
    end else if (accept) begin
      round_top         <= round_top_next;
      square_top        <= square_top_next;
      position          <= overflow_next ? position : op;
      overflow          <= overflow_next;
      sequence_error    <= sequence_error_next;
      round_part_error  <= round_part_error_next;
      square_part_error <= square_part_error_next;
      overlap_error     <= overlap_error_next;
    end
  end

endmodule

/* rtl/core/dbpp_out.sv */
// memory read stage and output register with flow control
module dbpp_out (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  dbpp_pkg::stage_t          stage,
  input  logic [dbpp_pkg::IdxW-1:0] round_rdata,
  input  logic [dbpp_pkg::IdxW-1:0] square_rdata,
  output logic                      take,
  dbpp_result_if.source             result
);
  import dbpp_pkg::*;

  logic            s1_valid;
  stage_t          s1;
  logic            advance;
  logic [IdxW-1:0] left_sel;

  // stage one moves on when the output register is free or being emptied
  assign advance = s1_valid && (!result.valid || result.ready);
  assign take    = !s1_valid || !result.valid || result.ready;

  // stage one: waits for the stack read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage;
    end
  end

  // opener position from whichever stack popped
  always_comb begin
    left_sel = '0;
    if (s1.pair_valid) begin
      left_sel = s1.sel_round ? round_rdata : square_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.pair_valid     <= s1.pair_valid;
      result.left_pos       <= left_sel;
      result.right_pos      <= s1.right_pos;
      result.status         <= s1.status;
      result.error_position <= s1.error_position;
      result.record_done    <= s1.record_done;
    end
  end

endmodule

/* rtl/core/dot_bracket_pair_parser.sv */
// top level of the dot-bracket pair parser
// a result goes through the stage one register, then the output register
// throughput: one word per cycle unless the output stalls; each word does at most one
// push or one pop on each stack ram (one write port and one read port per ram)
// reset: synchronous, clears stack pointers, position, errors, mode and valids;
// stack ram contents are not cleared
module dot_bracket_pair_parser (
  input  logic                          clk,
  input  logic                          rst,
  dbpp_item_if.sink                     item,
  dbpp_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbpp_pkg::CfgAddrW-1:0] paddr,
  input  logic [dbpp_pkg::CfgDataW-1:0] pwdata,
  output logic [dbpp_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import dbpp_pkg::*;

  logic            union_mode;
  logic            take;
  logic            accept;
  ram_req_t        round_req;
  ram_req_t        square_req;
  stage_t          stage;
  logic [IdxW-1:0] round_rdata;
  logic [IdxW-1:0] square_rdata;

  // input handshake
  assign item.ready = take;
  assign accept     = item.valid && take;

  // configuration
  dbpp_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .union_mode (union_mode)
  );

  // decode and stack control
  dbpp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .union_mode      (union_mode),
    .base_char       (item.base_char),
    .struct_char     (item.struct_char),
    .alt_struct_char (item.alt_struct_char),
    .last            (item.last),
    .round_req       (round_req),
    .square_req      (square_req),
    .stage           (stage)
  );

  // stacks
  dbpp_ram #(.Width(IdxW), .Depth(MaxLen)) u_round_ram (
    .clk   (clk),
    .we    (round_req.we),
    .waddr (round_req.waddr),
    .wdata (round_req.wdata),
    .re    (round_req.re),
    .raddr (round_req.raddr),
    .rdata (round_rdata)
  );

  dbpp_ram #(.Width(IdxW), .Depth(MaxLen)) u_square_ram (
    .clk   (clk),
    .we    (square_req.we),
    .waddr (square_req.waddr),
    .wdata (square_req.wdata),
    .re    (square_req.re),
    .raddr (square_req.raddr),
    .rdata (square_rdata)
  );

  // result stage
  dbpp_out u_out (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .stage        (stage),
    .round_rdata  (round_rdata),
    .square_rdata (square_rdata),
    .take         (take),
    .result       (result)
  );

endmodule

/* rtl/core/dbpp_checker.sv */
// port-level checks on the parser's result channel, bound to the top level
module dbpp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic                      pair_valid,
  input logic [dbpp_pkg::IdxW-1:0] left_pos,
  input logic [dbpp_pkg::IdxW-1:0] right_pos,
  input logic [2:0]                status,
  input logic [dbpp_pkg::PosW-1:0] error_position,
  input logic                      record_done
);
  import dbpp_pkg::*;

  // a waiting result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid after reset");

  // status only on the last word of a record
  a_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && !record_done |-> status == ERR_NONE && error_position == '0)
    else $error("status outside record end");

  // no positions without a pair
  a_pair: assert property (@(posedge clk) disable iff (rst)
    res_valid && !pair_valid |-> left_pos == '0 && right_pos == '0)
    else $error("positions without pair");

  // codes without a place report position zero
  a_epos: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ERR_NONE || status == ERR_MISSING || status == ERR_TOO_LONG)
    |-> error_position == '0)
    else $error("error position on positionless status");

endmodule

bind dot_bracket_pair_parser dbpp_checker u_dbpp_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .pair_valid     (result.pair_valid),
  .left_pos       (result.left_pos),
  .right_pos      (result.right_pos),
  .status         (result.status),
  .error_position (result.error_position),
  .record_done    (result.record_done)
);
